FILE: src/ect_pkg.sv
// Package: shared types, register indexes and date arithmetic helpers.
package ect_pkg;

	// Register indexes on the configuration port
	localparam logic [2:0] REG_SECONDS = 3'd0;
	localparam logic [2:0] REG_MINUTES = 3'd1;
	localparam logic [2:0] REG_HOURS   = 3'd2;
	localparam logic [2:0] REG_DAY     = 3'd3;
	localparam logic [2:0] REG_MONTH   = 3'd4;
	localparam logic [2:0] REG_YEAR    = 3'd5;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 7;

	// Units and tens-digit masks of the clock registers
	localparam logic [7:0] MASK_UNITS   = 8'h0F;
	localparam logic [7:0] MASK_TENS_SM = 8'h70;
	localparam logic [7:0] MASK_TENS_HD = 8'h30;
	localparam logic [7:0] MASK_TENS_MO = 8'h10;
	localparam logic [7:0] MASK_TENS_YR = 8'hF0;

	localparam logic signed [9:0] MOD_SEC_MIN = 10'sd60;
	localparam logic signed [9:0] MOD_HOURS   = 10'sd24;
	localparam logic signed [9:0] MOD_MONTHS  = 10'sd12;
	localparam logic signed [9:0] HI_SEC_MIN  = 10'sd59;
	localparam logic signed [9:0] HI_HOURS    = 10'sd23;
	localparam logic signed [9:0] HI_DAYS     = 10'sd31;
	localparam logic signed [9:0] HI_MONTHS   = 10'sd11;
	localparam logic signed [9:0] HI_YEARS    = 10'sd99;
	localparam logic signed [9:0] LO_YEARS    = -10'sd100;

	typedef struct packed {
		logic [7:0] sec_reg;
		logic [7:0] min_reg;
		logic [7:0] hour_reg;
		logic [7:0] date_reg;
		logic [7:0] month_reg;
		logic [7:0] year_reg;
	} item_t;

	typedef struct packed {
		logic [5:0]        diff_seconds;
		logic [5:0]        diff_minutes;
		logic [4:0]        diff_hours;
		logic [4:0]        diff_days;
		logic [3:0]        diff_months;
		logic signed [7:0] diff_years;
		logic              is_anniversary;
	} result_t;

	// Reference date registers
	typedef struct packed {
		logic [5:0] seconds;
		logic [5:0] minutes;
		logic [4:0] hours;
		logic [4:0] day;
		logic [3:0] month;
		logic [6:0] year;
	} ref_cfg_t;

	typedef struct packed {
		logic signed [9:0] val;
		logic              borrow;
	} wrap_t;

	// Decode a BCD register: units plus ten times the masked tens digit
	function automatic logic [7:0] bcd_decode(input logic [7:0] r, input logic [7:0] tens_mask);
		logic [7:0] tens;
		tens = (r & tens_mask) >> 4;
		return (r & MASK_UNITS) + tens * 8'd10;
	endfunction

	// Length of the reference month; February has 29 days in leap years of 20yy
	function automatic logic [4:0] month_days(input logic [3:0] m, input logic [6:0] yy);
		logic leap;
		leap = (yy[1:0] == 2'b00) && (yy != 7'd100);
		case (m)
			4'd2:                      month_days = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:   month_days = 5'd30;
			default:                   month_days = 5'd31;
		endcase
	endfunction

	// Wrap a negative difference by its modulus, flag a borrow, clamp to 0..hi
	function automatic wrap_t wrap_field(input logic signed [9:0] raw,
			input logic signed [9:0] modulus, input logic signed [9:0] hi);
		wrap_t w;
		logic signed [9:0] v;
		w.borrow = raw < 10'sd0;
		v = w.borrow ? raw + modulus : raw;
		if (v < 10'sd0) begin
			w.val = 10'sd0;
		end else if (v > hi) begin
			w.val = hi;
		end else begin
			w.val = v;
		end
		return w;
	endfunction

	// Widen an unsigned byte to a signed working value
	function automatic logic signed [9:0] to_s10(input logic [7:0] x);
		return $signed({2'b00, x});
	endfunction

endpackage

FILE: src/elapsed_calendar_time_unit.sv
// Top level: reference registers, input register and result register.
// An accepted word passes the input register and then the result register before done shows its result.
// Throughput: one word per cycle; busy stays low, the two-register path never stalls.
// The result is shown for one cycle only, since the receiver cannot hold it off.
// Reset (arst_n low, asynchronous) clears the pipeline valid flags and loads the
// reference date 2021-05-31 20:20:00.
module elapsed_calendar_time_unit
	import ect_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  item_t                 item,
	output logic                  done,
	output result_t               result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	ref_cfg_t ref_q;
	item_t    item_s1;
	logic     valid_s1;
	result_t  calc;
	result_t  result_q;
	logic     done_q;

	assign busy = 1'b0;

	// Write the reference registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_q.seconds <= 6'd0;
			ref_q.minutes <= 6'd20;
			ref_q.hours   <= 5'd20;
			ref_q.day     <= 5'd31;
			ref_q.month   <= 4'd5;
			ref_q.year    <= 7'd21;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SECONDS: ref_q.seconds <= cfg_data[5:0];
				REG_MINUTES: ref_q.minutes <= cfg_data[5:0];
				REG_HOURS:   ref_q.hours   <= cfg_data[4:0];
				REG_DAY:     ref_q.day     <= cfg_data[4:0];
				REG_MONTH:   ref_q.month   <= cfg_data[3:0];
				REG_YEAR:    ref_q.year    <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// Track valid words through both stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			done_q   <= valid_s1;
		end
	end

	// Capture the input word
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			item_s1 <= item;
		end
	end

	ect_calc u_calc (
		.item    (item_s1),
		.ref_cfg (ref_q),
		.result  (calc)
	);

	// Hold the result word
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			result_q <= calc;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

FILE: src/ect_calc.sv
// Datapath: decode one clock snapshot and subtract the reference with borrow.
module ect_calc
	import ect_pkg::*;
(
	input  item_t    item,
	input  ref_cfg_t ref_cfg,
	output result_t  result
);

	logic [7:0] cs, cm, ch, cd, cmo, cy;
	logic [4:0] dim;
	logic signed [9:0] raw_y, dy;
	wrap_t ws, wm, wh, wd, wmo;

	// Decode the BCD fields
	assign cs  = bcd_decode(item.sec_reg,   MASK_TENS_SM);
	assign cm  = bcd_decode(item.min_reg,   MASK_TENS_SM);
	assign ch  = bcd_decode(item.hour_reg,  MASK_TENS_HD);
	assign cd  = bcd_decode(item.date_reg,  MASK_TENS_HD);
	assign cmo = bcd_decode(item.month_reg, MASK_TENS_MO);
	assign cy  = bcd_decode(item.year_reg,  MASK_TENS_YR);

	assign dim = month_days(ref_cfg.month, ref_cfg.year);

	// Ripple the borrow from seconds up to years
	always_comb begin
		ws  = wrap_field(to_s10(cs) - to_s10({2'b00, ref_cfg.seconds}),
			MOD_SEC_MIN, HI_SEC_MIN);
		wm  = wrap_field(to_s10(cm) - to_s10({2'b00, ref_cfg.minutes})
			- $signed({9'd0, ws.borrow}), MOD_SEC_MIN, HI_SEC_MIN);
		wh  = wrap_field(to_s10(ch) - to_s10({3'd0, ref_cfg.hours})
			- $signed({9'd0, wm.borrow}), MOD_HOURS, HI_HOURS);
		wd  = wrap_field(to_s10(cd) - to_s10({3'd0, ref_cfg.day})
			- $signed({9'd0, wh.borrow}), $signed({5'd0, dim}), HI_DAYS);
		wmo = wrap_field(to_s10(cmo) - to_s10({4'd0, ref_cfg.month})
			- $signed({9'd0, wd.borrow}), MOD_MONTHS, HI_MONTHS);
		raw_y = to_s10(cy) - to_s10({1'b0, ref_cfg.year}) - $signed({9'd0, wmo.borrow});
		if (raw_y < LO_YEARS) begin
			dy = LO_YEARS;
		end else if (raw_y > HI_YEARS) begin
			dy = HI_YEARS;
		end else begin
			dy = raw_y;
		end
	end

	// Pack the result word
	always_comb begin
		result.diff_seconds   = ws.val[5:0];
		result.diff_minutes   = wm.val[5:0];
		result.diff_hours     = wh.val[4:0];
		result.diff_days      = wd.val[4:0];
		result.diff_months    = wmo.val[3:0];
		result.diff_years     = dy[7:0];
		result.is_anniversary = (cmo == {4'd0, ref_cfg.month}) && (cd == {3'd0, ref_cfg.day})
			&& (ch == {3'd0, ref_cfg.hours}) && (cm == {2'd0, ref_cfg.minutes});
	end

endmodule

FILE: src/ect_checker.sv
// Checker: port-level timing and range properties, bound to the top level.
module ect_checker
	import ect_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    start,
	input logic    busy,
	input logic    done,
	input result_t result
);

	// Every accepted word produces a result
	a_start_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> ##1 done)
		else $error("accepted word produced no result");

	// No result without an earlier accepted word
	a_done_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 2))
		else $error("result without accepted word");

	// Time fields stay in range
	a_time_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.diff_seconds <= 6'd59) && (result.diff_minutes <= 6'd59)
			&& (result.diff_hours <= 5'd23))
		else $error("time difference out of range");

	// Date fields stay in range
	a_date_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.diff_months <= 4'd11) && (result.diff_years >= -8'sd100)
			&& (result.diff_years <= 8'sd99))
		else $error("date difference out of range");

endmodule

bind elapsed_calendar_time_unit ect_checker u_ect_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);
